[sv/brars_pkg.sv]
// brars_pkg: shared constants for the block range-add / range-sum store.
// Holds parameter defaults, operation codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brars_pkg;
  localparam int unsigned DEPTH_DEF      = 65536;
  localparam int unsigned BLOCK_SIZE_DEF = 256;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MOD_W   = 33;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned ELEM_W  = 64;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
endpackage
`default_nettype wire

[sv/block_range_add_range_sum_top.sv]
// Block range-add / range-sum store: one item at a time under a small sequencer.
// Load: accept, split the index into its block, read, then write. Range add /
// query: accept and split the range into blocks, then a read and an operate step
// per edge element and a read, multiply and operate step per block touched; a
// query ends with the modulo on the restoring divider, plus any output stall.
// Empty query: straight to output; ignored beat: stays idle. A clearing pass
// after reset zeroes the block table, not the element store, and blocks all beats.
`timescale 1ns / 1ps
`default_nettype none
module block_range_add_range_sum_top #(
  parameter int unsigned DEPTH      = brars_pkg::DEPTH_DEF,
  parameter int unsigned BLOCK_SIZE = brars_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic        [brars_pkg::OP_W-1:0]      op_i,
  input  wire logic        [brars_pkg::INDEX_W-1:0]   first_index_i,
  input  wire logic        [brars_pkg::INDEX_W-1:0]   last_index_i,
  input  wire logic signed [brars_pkg::VALUE_W-1:0]   value_i,
  input  wire logic        [brars_pkg::MOD_W-1:0]     modulus_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic             [brars_pkg::RES_W-1:0]     residue_o
);
  import brars_pkg::*;

  // sizing
  localparam int unsigned NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned BLK_DEPTH  = (NUM_BLOCKS < 2) ? 2 : NUM_BLOCKS;
  localparam int unsigned BLK_W      = $clog2(BLK_DEPTH);
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(BLOCK_SIZE + 1);
  // exact sum of all terms: 64-bit terms, at most 2*DEPTH of them
  localparam int unsigned ACC_W      = ELEM_W + ADDR_W + 2;
  localparam int unsigned IT_W       = $clog2(ACC_W + 1);
  localparam int unsigned BW         = 2 * ELEM_W;

  // block number by reciprocal multiply: ceil(2^DIV_SH / BLOCK_SIZE) is exact
  // for every address below 2^ADDR_W
  localparam int unsigned BS_LOG  = $clog2(BLOCK_SIZE);
  localparam int unsigned DIV_SH  = ADDR_W + BS_LOG;
  localparam int unsigned SPLIT_W = 2 * ADDR_W + BS_LOG + 2;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << DIV_SH) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
  localparam logic [ADDR_W+1:0] RECIP = RECIP64[ADDR_W+1:0];

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVP  = 4'd2;
  localparam logic [3:0] S_DIVQ  = 4'd3;
  localparam logic [3:0] S_LD_RD = 4'd4;
  localparam logic [3:0] S_LD_WR = 4'd5;
  localparam logic [3:0] S_E_RD  = 4'd6;
  localparam logic [3:0] S_E_OP  = 4'd7;
  localparam logic [3:0] S_B_RD  = 4'd8;
  localparam logic [3:0] S_B_MUL = 4'd9;
  localparam logic [3:0] S_B_OP  = 4'd10;
  localparam logic [3:0] S_MOD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // segments of a range: leading edge, whole middle blocks, trailing edge
  localparam logic [1:0] SEG_A = 2'd0;
  localparam logic [1:0] SEG_M = 2'd1;
  localparam logic [1:0] SEG_B = 2'd2;

  function automatic logic [ADDR_W-1:0] blk_first(input logic [BLK_W-1:0] b);
    return ADDR_W'(32'(b) * 32'(BLOCK_SIZE));
  endfunction

  function automatic logic [ADDR_W-1:0] blk_last(input logic [BLK_W-1:0] b);
    logic [31:0] e;
    e = 32'(b) * 32'(BLOCK_SIZE) + 32'(BLOCK_SIZE - 1);
    if (e > 32'(DEPTH - 1)) e = 32'(DEPTH - 1);
    return ADDR_W'(e);
  endfunction

  logic [3:0]               state_q, state_d;
  logic [1:0]               seg_q, seg_d;
  logic [OP_W-1:0]          op_q, op_d;
  logic [ADDR_W-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic signed [VALUE_W-1:0] v_q, v_d;
  logic [MOD_W-1:0]         m_q, m_d;
  logic [BLK_W-1:0]         p_q, p_d, q_q, q_d, blk_q, blk_d;
  logic [ADDR_W-1:0]        idx_q, idx_d, end_q, end_d, seg_lo_q, seg_lo_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [ELEM_W-1:0]        prod_q, prod_d;
  logic [RES_W-1:0]         res_q, res_d;

  // ram ports
  logic              e_we, b_we;
  logic [ELEM_W-1:0] e_wdata, e_rdata;
  logic [BW-1:0]     b_wdata, b_rdata;
  logic [ELEM_W-1:0] b_sum, b_pend;

  // divider ports
  logic              div_start, div_busy, div_done;
  logic [ACC_W-1:0]  div_num;
  logic [MOD_W-1:0]  div_den, div_rem;
  logic [IT_W-1:0]   div_iters;

  // block split
  logic [ADDR_W-1:0]  split_in;
  logic [SPLIT_W-1:0] split_prod;
  logic [BLK_W-1:0]   split_blk;

  // accept-time checks
  logic              accept;
  logic              lo_ok, empty;
  logic [ADDR_W-1:0] hi_cl;
  logic [MOD_W-1:0]  m_cl;
  logic [ELEM_W-1:0] vx;
  logic [CNT_W-1:0]  cnt_sel;
  logic [ELEM_W-1:0] mul_a;

  assign accept = in_valid_i && in_ready_o;
  assign lo_ok  = 32'(first_index_i) < 32'(DEPTH);
  assign hi_cl  = (32'(last_index_i) > 32'(DEPTH - 1)) ? ADDR_W'(DEPTH - 1)
                                                      : ADDR_W'(last_index_i);
  assign empty  = !lo_ok || (32'(first_index_i) > 32'(hi_cl));
  // anything above 2^32 counts as 2^32
  assign m_cl   = (modulus_i[MOD_W-1] && (modulus_i[MOD_W-2:0] != '0))
                  ? {1'b1, {(MOD_W-1){1'b0}}} : modulus_i;

  assign vx     = ELEM_W'(v_q);
  assign b_sum  = b_rdata[BW-1:ELEM_W];
  assign b_pend = b_rdata[ELEM_W-1:0];

  // first index while splitting it, last index on the following cycle
  assign split_in   = (state_q == S_DIVQ) ? hi_q : lo_q;
  assign split_prod = SPLIT_W'(split_in) * SPLIT_W'(RECIP);
  assign split_blk  = split_prod[DIV_SH +: BLK_W];

  // middle blocks are never the short last block
  assign cnt_sel = (seg_q == SEG_M) ? CNT_W'(BLOCK_SIZE)
                 : CNT_W'({1'b0, end_q} - {1'b0, seg_lo_q} + 1'b1);
  assign mul_a   = (op_q == OP_ADD) ? vx : b_pend;

  always_comb begin
    state_d  = state_q;
    seg_d    = seg_q;
    op_d     = op_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    v_d      = v_q;
    m_d      = m_q;
    p_d      = p_q;
    q_d      = q_q;
    blk_d    = blk_q;
    idx_d    = idx_q;
    end_d    = end_q;
    seg_lo_d = seg_lo_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    res_d    = res_q;
    e_we     = 1'b0;
    e_wdata  = e_rdata + vx;
    b_we     = 1'b0;
    b_wdata  = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = m_q;
    div_iters = IT_W'(ACC_W);

    case (state_q)
      S_CLR: begin
        b_we = 1'b1;
        if (32'(blk_q) == 32'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end else begin
          blk_d = blk_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d  = op_i;
          lo_d  = ADDR_W'(first_index_i);
          idx_d = ADDR_W'(first_index_i);
          hi_d  = hi_cl;
          v_d   = value_i;
          m_d   = m_cl;
          acc_d = '0;
          case (op_i)
            OP_LOAD: begin
              if (lo_ok) state_d = S_DIVP;
            end
            OP_ADD: begin
              if (!empty) state_d = S_DIVP;
            end
            OP_QUERY: begin
              if (empty || (m_cl == '0)) begin
                res_d   = '0;
                state_d = S_OUT;
              end else begin
                state_d = S_DIVP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIVP: begin
        p_d   = split_blk;
        blk_d = split_blk;
        if (op_q == OP_LOAD) begin
          state_d = S_LD_RD;
        end else begin
          state_d = S_DIVQ;
        end
      end
      S_DIVQ: begin
        q_d      = split_blk;
        seg_d    = SEG_A;
        blk_d    = p_q;
        idx_d    = lo_q;
        seg_lo_d = lo_q;
        end_d    = (split_blk == p_q) ? hi_q : blk_last(p_q);
        state_d  = S_E_RD;
      end
      S_LD_RD: state_d = S_LD_WR;
      S_LD_WR: begin
        // a repeated load adds to the block sum again
        e_we    = 1'b1;
        e_wdata = vx;
        b_we    = 1'b1;
        b_wdata = {b_sum + vx, b_pend};
        state_d = S_IDLE;
      end
      S_E_RD: state_d = S_E_OP;
      S_E_OP: begin
        if (op_q == OP_ADD) begin
          e_we = 1'b1;
        end else begin
          acc_d = acc_q + ACC_W'($signed(e_rdata));
        end
        if (idx_q == end_q) begin
          state_d = S_B_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_E_RD;
        end
      end
      S_B_RD: state_d = S_B_MUL;
      S_B_MUL: begin
        prod_d = mul_a * ELEM_W'(cnt_sel);
        if ((op_q != OP_ADD) && (seg_q == SEG_M)) begin
          acc_d = acc_q + ACC_W'($signed(b_sum));
        end
        state_d = S_B_OP;
      end
      S_B_OP: begin
        if (op_q == OP_ADD) begin
          b_we    = 1'b1;
          b_wdata = (seg_q == SEG_M) ? {b_sum, b_pend + vx} : {b_sum + prod_q, b_pend};
        end else begin
          acc_d = acc_q + ACC_W'($signed(prod_q));
        end
        // next segment, or finish
        if ((seg_q == SEG_A) && (32'(q_q) > 32'(p_q) + 32'd1)) begin
          seg_d   = SEG_M;
          blk_d   = p_q + 1'b1;
          state_d = S_B_RD;
        end else if ((seg_q == SEG_M) && (32'(blk_q) + 32'd1 < 32'(q_q))) begin
          blk_d   = blk_q + 1'b1;
          state_d = S_B_RD;
        end else if ((seg_q == SEG_B) || ((seg_q == SEG_A) && (p_q == q_q))) begin
          if (op_q == OP_ADD) begin
            state_d = S_IDLE;
          end else begin
            // acc_d already holds the last term; fold it into the magnitude
            div_start = 1'b1;
            div_num   = acc_d[ACC_W-1] ? ACC_W'(-acc_d) : ACC_W'(acc_d);
            div_den   = m_q;
            div_iters = IT_W'(ACC_W);
            state_d   = S_MOD;
          end
        end else begin
          seg_d    = SEG_B;
          blk_d    = q_q;
          idx_d    = blk_first(q_q);
          seg_lo_d = blk_first(q_q);
          end_d    = hi_q;
          state_d  = S_E_RD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          // negative sums map to m - r unless r is zero
          res_d = (acc_q[ACC_W-1] && (div_rem != '0)) ? RES_W'(m_q - div_rem)
                                                       : RES_W'(div_rem);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      blk_q   <= '0;
      seg_q   <= SEG_A;
      op_q    <= OP_LOAD;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      seg_q   <= seg_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    v_q      <= v_d;
    m_q      <= m_d;
    p_q      <= p_d;
    q_q      <= q_d;
    idx_q    <= idx_d;
    end_q    <= end_d;
    seg_lo_q <= seg_lo_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  brars_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (idx_q),
    .wdata_i (e_wdata),
    .raddr_i (idx_q),
    .rdata_o (e_rdata)
  );

  // block table: {sum, pending add}
  brars_ram #(.WIDTH(BW), .DEPTH(BLK_DEPTH)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (blk_q),
    .wdata_i (b_wdata),
    .raddr_i (blk_q),
    .rdata_o (b_rdata)
  );

  brars_div #(.NUM_W(ACC_W), .DEN_W(MOD_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign residue_o   = res_q;

  // checks
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_mod_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (m_q != '0)) else $error("modulo by zero");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E_OP) |-> (idx_q <= end_q)) else $error("element walk overran");
  a_blk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLR) |-> (32'(blk_q) < 32'(NUM_BLOCKS)))
    else $error("block index out of range");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MOD) && !div_done) |=> (state_q == S_MOD) || $past(div_done))
    else $error("left modulo step early");
endmodule
`default_nettype wire

[sv/brars_ram.sv]
// brars_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module brars_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/brars_div.sv]
// brars_div: restoring divider, one quotient bit per cycle; only the remainder is used.
// Dividend is left-aligned by the caller; runs iters_i steps. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module brars_div #(
  parameter int unsigned NUM_W = 96,
  parameter int unsigned DEN_W = 33
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [NUM_W-1:0]           num_i,
  input  wire logic [DEN_W-1:0]           den_i,
  input  wire logic [$clog2(NUM_W+1)-1:0] iters_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [DEN_W-1:0]                rem_o
);
  localparam int unsigned IT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [IT_W-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = iters_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == IT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for block_range_add_range_sum_top.
// Drives load / range-add / range-query beats, predicts each residue in a local
// copy of the store, checks every output beat. Depends on brars_pkg and the top.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import brars_pkg::*;

  localparam int unsigned NELEM   = DEPTH_DEF;
  localparam int unsigned BSZ     = BLOCK_SIZE_DEF;
  localparam int unsigned NBLK    = (NELEM + BSZ - 1) / BSZ;
  localparam int unsigned IDLE_LIMIT = 20000; // cycles with no beat before giving up
  localparam int unsigned DRAIN   = 3000;     // a long range add still in flight at the end
  localparam int unsigned HOLD_OFF = 600;     // long receiver stall for back-pressure

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [OP_W-1:0]           op_i = OP_LOAD;
  logic [INDEX_W-1:0]        first_index_i = '0;
  logic [INDEX_W-1:0]        last_index_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic [MOD_W-1:0]          modulus_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [RES_W-1:0]          residue_o;

  // op 3 has no name in the package; the block must ignore it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  block_range_add_range_sum_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .first_index_i, .last_index_i,
    .value_i, .modulus_i, .out_valid_o, .out_ready_i, .residue_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Local copy of the store
  bit [63:0] elem_mirror [NELEM];
  bit        elem_loaded [NELEM];
  bit [63:0] blk_total [NBLK];
  bit [63:0] blk_pending [NBLK];

  bit [RES_W-1:0] residue_q [$];  // residues still owed by the block
  int errors = 0;
  bit quiet = 1'b0;       // final stretch: no idling on either side
  bit hold_req = 1'b0;    // asks the receiver for one long stall

  function automatic longint unsigned blk_end(longint unsigned b);
    longint unsigned e;
    e = b * BSZ + BSZ - 1;
    return (e > NELEM - 1) ? NELEM - 1 : e;
  endfunction

  // non-negative residue of a 64-bit two's complement value
  function automatic longint unsigned signed_res(longint unsigned x, longint unsigned m);
    longint unsigned r;
    if (!x[63]) return x % m;
    r = (-x) % m;
    return (r == 0) ? 0 : m - r;
  endfunction

  function automatic void add_edge(longint unsigned lo, longint unsigned hi,
                                   longint unsigned d);
    for (longint unsigned i = lo; i <= hi; i++) elem_mirror[i] += d;
    blk_total[lo / BSZ] += (hi - lo + 1) * d;
  endfunction

  function automatic longint unsigned sum_edge(longint unsigned lo, longint unsigned hi,
                                               longint unsigned m, longint unsigned acc);
    for (longint unsigned i = lo; i <= hi; i++)
      acc = (acc + signed_res(elem_mirror[i], m)) % m;
    return (acc + signed_res(blk_pending[lo / BSZ] * (hi - lo + 1), m)) % m;
  endfunction

  // Applies one accepted beat to the local store; queues a residue for a query.
  function automatic void apply_beat(logic [OP_W-1:0] op, longint unsigned lo,
                                     longint unsigned hi, logic [VALUE_W-1:0] val,
                                     longint unsigned m);
    longint unsigned d, p, q, acc;
    bit empty;
    d = {{32{val[31]}}, val};
    if (op == OP_LOAD) begin
      elem_mirror[lo] = d;
      elem_loaded[lo] = 1'b1;
      blk_total[lo / BSZ] += d;
      return;
    end
    if (op == OP_UNUSED) return;
    empty = lo > hi;
    p = lo / BSZ;
    q = hi / BSZ;
    if (op == OP_ADD) begin
      if (empty) return;
      if (p == q) add_edge(lo, hi, d);
      else begin
        for (longint unsigned b = p + 1; b < q; b++) blk_pending[b] += d;
        add_edge(lo, blk_end(p), d);
        add_edge(q * BSZ, hi, d);
      end
      return;
    end
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    if (m == 0 || empty) begin
      residue_q.push_back('0);
      return;
    end
    acc = 0;
    if (p == q) acc = sum_edge(lo, hi, m, acc);
    else begin
      for (longint unsigned b = p + 1; b < q; b++) begin
        acc = (acc + signed_res(blk_total[b], m)) % m;
        acc = (acc + signed_res(blk_pending[b] * (blk_end(b) - b * BSZ + 1), m)) % m;
      end
      acc = sum_edge(lo, blk_end(p), m, acc);
      acc = sum_edge(q * BSZ, hi, m, acc);
    end
    residue_q.push_back(acc[RES_W-1:0]);
  endfunction

  // Offers one beat, at times with a random gap in front, and waits for it to be taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic [INDEX_W-1:0] lo,
                           logic [INDEX_W-1:0] hi, logic [VALUE_W-1:0] val,
                           logic [MOD_W-1:0] m);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    op_i <= op;
    first_index_i <= lo;
    last_index_i <= hi;
    value_i <= val;
    modulus_i <= m;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_beat(op, lo, hi, val, m);
  endtask

  // Loads every edge element of the range that was never written, so that
  // neither an add nor a query ever reads undefined store contents.
  task automatic prime_range(int unsigned lo, int unsigned hi);
    int unsigned p, q;
    p = lo / BSZ;
    q = hi / BSZ;
    for (int unsigned i = lo; i <= hi; i++) begin
      if (p != q && i > blk_end(p) && i < q * BSZ) i = q * BSZ;
      if (!elem_loaded[i]) send_beat(OP_LOAD, INDEX_W'(i), '0, $urandom(), '0);
    end
  endtask

  function automatic logic [MOD_W-1:0] rand_modulus();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 33'h1_0000_0000;
      2: return {1'b1, $urandom()};
      3, 4: return MOD_W'($urandom_range(1, 1000));
      default: return {1'b0, $urandom()};
    endcase
  endfunction

  task automatic test_load_extremes();
    send_beat(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 0);
    send_beat(OP_LOAD, 1, 0, 32'h8000_0000, 0);
    send_beat(OP_LOAD, 2, 0, 32'hFFFF_FFFF, 0);
    send_beat(OP_LOAD, 3, 0, 32'd5, 0);
    send_beat(OP_QUERY, 0, 3, 0, 33'h1_0000_0000);
    send_beat(OP_QUERY, 0, 3, 0, 33'h1_FFFF_FFFF);
    send_beat(OP_QUERY, 0, 3, 0, 33'd1);
    send_beat(OP_QUERY, 0, 3, 0, 33'd7);
    // reload: block sum keeps the old value as well
    send_beat(OP_LOAD, 2, 0, 32'd9, 0);
    send_beat(OP_QUERY, 0, 3, 0, 33'd1000);
    for (int i = 65532; i <= 65535; i++) send_beat(OP_LOAD, INDEX_W'(i), 0, $urandom(), 0);
    send_beat(OP_ADD, 65532, 65535, 32'h8000_0000, 0);
    send_beat(OP_QUERY, 65532, 65535, 0, 33'h1_0000_0000);
  endtask

  task automatic test_special_cases();
    send_beat(OP_QUERY, 0, 3, 0, 33'd0);
    send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_beat(OP_ADD, 10, 5, 32'd77, 0);
    send_beat(OP_QUERY, 65535, 0, 0, 33'd13);
    send_beat(OP_QUERY, 1, 2, 0, 33'd3);
  endtask

  task automatic test_wide_range();
    prime_range(250, 65285);
    send_beat(OP_ADD, 250, 65285, -32'sd3, 0);
    send_beat(OP_QUERY, 250, 65285, 0, 33'd1_000_000_007);
    send_beat(OP_QUERY, 250, 65285, 0, 33'h1_0000_0000);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned k, p, q, lo, hi;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) hold_req = 1'b1;
      if (i >= n - n / 6) quiet = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 15)
        send_beat(OP_LOAD, INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom(),
                  rand_modulus());
      else if (k < 20)
        send_beat(OP_UNUSED, INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom(),
                  rand_modulus());
      else if (k < 25) begin
        lo = $urandom_range(1, NELEM - 1);
        send_beat(k < 23 ? OP_QUERY : OP_ADD, INDEX_W'(lo),
                  INDEX_W'($urandom_range(0, lo - 1)), $urandom(), rand_modulus());
      end else begin
        p = $urandom_range(0, NBLK - 1);
        q = p + (($urandom_range(0, 3) == 0) ? $urandom_range(0, NBLK - 1 - p)
                                              : $urandom_range(0, (NBLK - 1 - p) < 3 ?
                                                                 NBLK - 1 - p : 3));
        if (p == q) begin
          lo = p * BSZ + $urandom_range(0, BSZ - 1);
          hi = lo + $urandom_range(0, 15);
          if (hi > blk_end(p)) hi = 32'(blk_end(p));
        end else begin
          lo = 32'(blk_end(p)) - $urandom_range(0, 15);
          hi = q * BSZ + $urandom_range(0, 15);
        end
        prime_range(lo, hi);
        send_beat(k < 55 ? OP_ADD : OP_QUERY, INDEX_W'(lo), INDEX_W'(hi), $urandom(),
                  rand_modulus());
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < HOLD_OFF; c++) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else out_ready_i <= 1'b1;
    end
  end

  // Result check against the oldest owed residue
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (residue_q.size() == 0) begin
        $error("unexpected result beat, residue %0h", residue_o);
        errors++;
      end else begin
        if (residue_o !== residue_q[0]) begin
          $error("residue: expected %0h, got %0h", residue_q[0], residue_o);
          errors++;
        end
        void'(residue_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any beat on either channel
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // each random step brings roughly a dozen beats with its edge loads
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_extremes();
    test_special_cases();
    test_wide_range();
    test_random(58);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
`default_nettype wire
